FILE: design/smcp_pkg.sv
// Shared codes and constants for the serial monitor command parser.
package smcp_pkg;

    typedef enum logic [3:0] {
        ACT_CLEAR    = 4'd0,
        ACT_SET_ADDR = 4'd1,
        ACT_WRITE    = 4'd2,
        ACT_READ     = 4'd3,
        ACT_EXECUTE  = 4'd4,
        ACT_MEMTEST  = 4'd5,
        ACT_IGNORED  = 4'd6,
        ACT_CHK_ERR  = 4'd7,
        ACT_SYN_ERR  = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_SET_ADDR = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_READ     = 3'd3,
        CMD_EXECUTE  = 3'd4,
        CMD_MEMTEST  = 3'd5
    } t_cmd;

    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_SPACE  = 8'h20;
    localparam logic [31:0] MEMTEST_END = 32'h400E_0000;
    localparam logic [31:0] WORD_STEP   = 32'd4;

endpackage

FILE: design/serial_monitor_command_parser.sv
// Serial monitor command parser: byte-wise line parser, one action per command line.
//
// Each accepted byte is registered, then decoded by a small parse state machine; a
// line's action reaches the result port once its newline (or failing byte) has passed
// through the input register and then the output register, waiting in the skid register
// while the output stalls. One byte is taken every cycle while o_ready is high. A
// two-entry result buffer (output register plus skid register) lets the parser keep
// consuming while a result waits; o_ready drops only when both entries are full.
module serial_monitor_command_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output smcp_pkg::t_action     o_action,
    output logic [31:0]           o_word_address,
    output logic [31:0]           o_argument,
    output logic [7:0]            o_computed_sum,
    output logic [7:0]            o_received_sum
);
    import smcp_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_SPACE1 = 3'd1,
        PH_ARG    = 3'd2,
        PH_SPACE2 = 3'd3,
        PH_CHK    = 3'd4,
        PH_SPACE3 = 3'd5,
        PH_DROP   = 3'd6
    } t_phase;

    typedef struct packed {
        t_action     action;
        logic [31:0] word_address;
        logic [31:0] argument;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
    } t_result;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parse state
    t_phase      r_phase,   n_phase;
    logic [2:0]  r_cmd,     n_cmd;
    logic [31:0] r_acc,     n_acc;
    logic [7:0]  r_sum,     n_sum;
    logic [7:0]  r_given,   n_given;
    logic [31:0] r_addr,    n_addr;
    logic        r_err,     n_err;

    // result buffer
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        proc_fire;
    logic        res_valid;
    t_result     res;

    logic [7:0]  ch;
    logic        is_hex;
    logic [3:0]  hex_v;
    logic        is_lf;
    logic        is_space;
    logic        after_arg;
    logic        check_done;
    logic        after_check;
    logic        finish;
    logic        do_fail;
    t_action     fail_act;
    logic [7:0]  emit_given;
    logic        out_free;

    assign o_ready   = !r_skid_valid;
    assign proc_fire = r_in_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || i_ready;

    // fold case, map CR to LF, decode hex digit
    always_comb begin
        ch = (r_in_byte == CHAR_CR) ? CHAR_LF : r_in_byte;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            ch = ch + 8'h20;
        end
        is_hex = 1'b0;
        hex_v  = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            is_hex = 1'b1;
            hex_v  = ch[3:0];
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            is_hex = 1'b1;
            hex_v  = ch[3:0] + 4'd9;
        end
        is_lf    = (ch == CHAR_LF);
        is_space = (ch == CHAR_SPACE);
    end

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_given     = r_given;
        n_addr      = r_addr;
        n_err       = r_err;
        after_arg   = 1'b0;
        check_done  = 1'b0;
        after_check = 1'b0;
        finish      = 1'b0;
        do_fail     = 1'b0;
        fail_act    = ACT_SYN_ERR;
        emit_given  = r_given;
        res_valid   = 1'b0;
        res.action  = ACT_IGNORED;

        case (r_phase)
            PH_SPACE1: begin
                if (is_hex) begin
                    n_acc   = {28'd0, hex_v};
                    n_sum   = r_sum + ch;
                    n_phase = PH_ARG;
                end else if (!is_space) begin
                    after_arg = 1'b1;
                end
            end
            PH_ARG: begin
                if (is_hex) begin
                    n_acc = {r_acc[27:0], hex_v};
                    n_sum = r_sum + ch;
                end else begin
                    after_arg = 1'b1;
                end
            end
            PH_SPACE2: after_arg = 1'b1;
            PH_CHK: begin
                if (is_hex) begin
                    n_given = {r_given[3:0], hex_v};
                end else begin
                    check_done = 1'b1;
                end
            end
            PH_SPACE3: after_check = 1'b1;
            PH_DROP: begin
                if (is_lf) begin
                    n_phase = PH_WAIT;
                end
            end
            default: begin
                n_phase = PH_SPACE1;
                n_sum   = ch;
                n_acc   = '0;
                n_given = '0;
                case (ch)
                    8'h63: n_cmd = CMD_CLEAR;
                    8'h6C: n_cmd = CMD_SET_ADDR;
                    8'h77: n_cmd = CMD_WRITE;
                    8'h72: n_cmd = CMD_READ;
                    8'h65: n_cmd = CMD_EXECUTE;
                    8'h74: n_cmd = CMD_MEMTEST;
                    default: begin
                        // skip cruft before the letter
                        n_phase = PH_WAIT;
                        n_sum   = r_sum;
                        n_acc   = r_acc;
                        n_given = r_given;
                    end
                endcase
            end
        endcase

        if (after_arg) begin
            if (is_space) begin
                n_phase = PH_SPACE2;
            end else if (is_lf) begin
                finish = 1'b1;
            end else if (is_hex) begin
                n_given = {4'd0, hex_v};
                n_phase = PH_CHK;
            end else begin
                // garbage counts as an empty checksum of zero
                n_given    = '0;
                emit_given = '0;
                check_done = 1'b1;
            end
        end

        if (check_done) begin
            if (r_sum != emit_given) begin
                do_fail  = 1'b1;
                fail_act = ACT_CHK_ERR;
            end else begin
                after_check = 1'b1;
            end
        end

        if (after_check) begin
            if (is_space) begin
                n_phase = PH_SPACE3;
            end else if (is_lf) begin
                finish = 1'b1;
            end else begin
                do_fail  = 1'b1;
                fail_act = ACT_SYN_ERR;
            end
        end

        if (finish) begin
            res_valid = 1'b1;
            n_phase   = PH_WAIT;
            if (r_err && r_cmd != CMD_CLEAR && r_cmd != CMD_MEMTEST) begin
                res.action = ACT_IGNORED;
            end else begin
                res.action = (r_cmd <= CMD_MEMTEST) ? t_action'({1'b0, r_cmd}) : ACT_IGNORED;
                case (r_cmd)
                    CMD_CLEAR:    n_err  = 1'b0;
                    CMD_SET_ADDR: n_addr = r_acc;
                    CMD_WRITE,
                    CMD_READ:     n_addr = r_addr + WORD_STEP;
                    CMD_EXECUTE: begin
                        n_addr = '0;
                        n_err  = 1'b0;
                    end
                    CMD_MEMTEST:  n_addr = MEMTEST_END;
                    default: ;
                endcase
            end
        end

        if (do_fail) begin
            res_valid  = 1'b1;
            res.action = fail_act;
            n_err      = 1'b1;
            n_phase    = is_lf ? PH_WAIT : PH_DROP;
        end

        res.word_address = r_addr;
        res.argument     = r_acc;
        res.computed_sum = r_sum;
        res.received_sum = emit_given;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_WAIT;
            r_cmd        <= '0;
            r_acc        <= '0;
            r_sum        <= '0;
            r_given      <= '0;
            r_addr       <= '0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (proc_fire) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_acc   <= n_acc;
                r_sum   <= n_sum;
                r_given <= n_given;
                r_addr  <= n_addr;
                r_err   <= n_err;
            end
            // drain skid first; hold a new result in skid while output stalls
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= proc_fire && res_valid;
                end
            end else if (proc_fire && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (proc_fire && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_action       = r_out.action;
    assign o_word_address = r_out.word_address;
    assign o_argument     = r_out.argument;
    assign o_computed_sum = r_out.computed_sum;
    assign o_received_sum = r_out.received_sum;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    a_result_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && res_valid) |=> (r_phase == PH_WAIT || r_phase == PH_DROP))
        else $error("result emitted without ending the line");
`endif

endmodule
